/* design/nbfd_pkg.sv */
package nbfd_pkg;

    localparam int FREQ_W    = 18;
    localparam int FP_W      = 19;
    localparam int FM_W      = 20;
    localparam int M_W       = 20;
    localparam int DIV_W     = 56;
    localparam int DVS_W     = 32;
    localparam int CNT_W     = 6;
    localparam int P_W       = 31;
    localparam int Q_W       = 20;
    localparam int KK_W      = 9;
    localparam int PROD_W    = 40;
    localparam int CFG_IDX_W = 2;
    localparam int A_SHIFT   = 15;

    localparam logic [FM_W-1:0]  M_START_NUM  = 20'd50000;
    localparam logic [FM_W-1:0]  FM_LIMIT     = 20'd648533;
    localparam logic [FM_W-1:0]  K_STEP_M1    = 20'd2749;
    localparam logic [DVS_W-1:0] HALF_VCO_KHZ = 32'd5836800;
    localparam logic [DVS_W-1:0] V_NUMER      = 32'd1494220800;
    localparam logic [DVS_W-1:0] K_STEP       = 32'd2750;
    localparam logic [M_W-1:0]   M_MAX        = 20'd1023;
    localparam logic [M_W-1:0]   FLAG_COARSE  = 20'd10;
    localparam logic [6:0]       A_OFFSET     = 7'd113;

    localparam logic [1:0] KIND_ONE   = 2'd0;
    localparam logic [1:0] KIND_MIXED = 2'd1;
    localparam logic [1:0] KIND_TWO   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_KHZ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_KHZ = 2'd1;

    typedef logic [FREQ_W-1:0] t_khz;

    localparam t_khz MIN_KHZ_RST = 18'd1000;
    localparam t_khz MAX_KHZ_RST = 18'd200099;

endpackage

/* design/nbfd_ifs.sv */
interface nbfd_req_if;
    import nbfd_pkg::*;
    logic valid;
    logic ready;
    t_khz freq_khz;
    modport source (output valid, output freq_khz, input ready);
    modport sink (input valid, input freq_khz, output ready);
endinterface

interface nbfd_cfg_if;
    import nbfd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_khz                 data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface nbfd_plan_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [9:0]  coarse_m;
    logic [37:0] fine_num;
    logic [29:0] fine_den;
    logic [31:0] a_word;
    logic [1:0]  run_class;
    logic        coarse_flag;
    logic        coarse_written;
    logic [9:0]  coarse_value;
    modport source (output valid, output ok, output coarse_m, output fine_num,
                    output fine_den, output a_word, output run_class, output coarse_flag,
                    output coarse_written, output coarse_value, input ready);
    modport sink (input valid, input ok, input coarse_m, input fine_num,
                  input fine_den, input a_word, input run_class, input coarse_flag,
                  input coarse_written, input coarse_value, output ready);
endinterface

/* design/nb_fractional_divider_planner.sv */
// Channel  | Dir | Payload
// i_cfg    | in  | index (0 min_khz, 1 max_khz), data
// i_req    | in  | freq_khz
// o_plan   | out | ok, coarse_m, fine_num, fine_den, a_word, run_class, coarse flag/written/value
//
// One transaction at a time: i_req.ready is high only while idle.
// Every division (hunt start, hunt modulo, gcd steps, p, q, K, A word, run base) runs
// on one shared restoring divider.
// Synchronous active-low reset returns to idle; config accepted every cycle.
// The result holds on o_plan until taken; no new request is taken meanwhile.
module nb_fractional_divider_planner #(
    parameter int RUN_LENGTH = 100,
    parameter int NORM_BITS  = 38
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nbfd_cfg_if.sink     i_cfg,
    nbfd_req_if.sink     i_req,
    nbfd_plan_if.source  o_plan
);
    import nbfd_pkg::*;

    localparam int RI_W = $clog2(RUN_LENGTH + 1);
    localparam logic [DVS_W-1:0] RUN_DIV = DVS_W'(RUN_LENGTH);
    localparam logic [RI_W-1:0]  RUN_END = RI_W'(RUN_LENGTH);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DIV     = 5'd1;
    localparam logic [4:0] S_PM_DIVD = 5'd2;
    localparam logic [4:0] S_PM_MODD = 5'd3;
    localparam logic [4:0] S_PM_END  = 5'd4;
    localparam logic [4:0] S_GCD     = 5'd5;
    localparam logic [4:0] S_GCDD    = 5'd6;
    localparam logic [4:0] S_PD      = 5'd7;
    localparam logic [4:0] S_QD      = 5'd8;
    localparam logic [4:0] S_KD      = 5'd9;
    localparam logic [4:0] S_MUL     = 5'd10;
    localparam logic [4:0] S_A       = 5'd11;
    localparam logic [4:0] S_AD      = 5'd12;
    localparam logic [4:0] S_NORM    = 5'd13;
    localparam logic [4:0] S_BASED   = 5'd14;
    localparam logic [4:0] S_RUN     = 5'd15;
    localparam logic [4:0] S_FIN     = 5'd16;
    localparam logic [4:0] S_OUT     = 5'd17;

    logic [4:0]           r_state, n_state, r_ret, n_ret;
    t_khz                 r_min, r_max;
    logic [DIV_W-1:0]     r_dvd, n_dvd;
    logic [DVS_W-1:0]     r_rem, n_rem, r_dvs, n_dvs;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    t_khz                 r_f, n_f;
    logic [FP_W-1:0]      r_fp, n_fp;
    logic                 r_main, n_main;
    logic [M_W-1:0]       r_m, n_m, r_m0, n_m0;
    logic [FM_W-1:0]      r_fm, n_fm, r_fm0, n_fm0, r_fmm, n_fmm;
    logic [9:0]           r_mm, n_mm;
    logic [DVS_W-1:0]     r_ga, n_ga, r_gb, n_gb, r_g, n_g;
    logic [P_W-1:0]       r_p, n_p;
    logic [Q_W-1:0]       r_q, n_q;
    logic [KK_W-1:0]      r_kk, n_kk;
    logic [PROD_W-1:0]    r_prod, n_prod;
    logic [31:0]          r_a, n_a;
    logic [NORM_BITS-1:0] r_num, n_num;
    logic [29:0]          r_den, n_den;
    t_khz                 r_base, n_base;
    logic [RI_W-1:0]      r_i, n_i;
    logic                 r_any1, n_any1, r_any2, n_any2, r_off10, n_off10;
    logic                 r_ok, n_ok;
    logic [1:0]           r_kind, n_kind;
    logic                 r_flag, n_flag, r_wr, n_wr;
    logic [9:0]           r_cv, n_cv;

    logic [DVS_W-1:0]  w_rem_sh;
    logic [DVS_W:0]    w_diff;
    logic [FM_W-1:0]   w_nstart, w_fm_inc;
    logic [M_W-1:0]    w_m_inc;
    logic [FP_W-1:0]   w_fp_run;
    logic [PROD_W-1:0] w_prod;
    logic [PROD_W:0]   w_sum;
    logic [DVS_W-1:0]  w_q7;
    logic [63:0]       w_num64;

    assign w_rem_sh = {r_rem[DVS_W-2:0], r_dvd[DIV_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {1'b0, r_dvs};
    assign w_nstart = M_START_NUM + FM_W'(r_fp) - FM_W'(1);
    assign w_fm_inc = r_fm + FM_W'(r_fp);
    assign w_m_inc  = r_m + M_W'(1);
    assign w_fp_run = FP_W'(r_base) + FP_W'(r_i);
    assign w_prod   = r_kk * r_p;
    assign w_sum    = {1'b0, r_prod} + (PROD_W+1)'(r_q) * (PROD_W+1)'(A_OFFSET);
    assign w_q7     = (DVS_W'(r_q) << 3) - DVS_W'(r_q);
    assign w_num64  = 64'(r_num);

    always_comb begin
        n_state = r_state;  n_ret = r_ret;
        n_dvd = r_dvd;  n_rem = r_rem;  n_dvs = r_dvs;  n_cnt = r_cnt;
        n_f = r_f;  n_fp = r_fp;  n_main = r_main;
        n_m = r_m;  n_m0 = r_m0;  n_fm = r_fm;  n_fm0 = r_fm0;  n_fmm = r_fmm;  n_mm = r_mm;
        n_ga = r_ga;  n_gb = r_gb;  n_g = r_g;  n_p = r_p;  n_q = r_q;  n_kk = r_kk;
        n_prod = r_prod;  n_a = r_a;  n_num = r_num;  n_den = r_den;
        n_base = r_base;  n_i = r_i;  n_any1 = r_any1;  n_any2 = r_any2;  n_off10 = r_off10;
        n_ok = r_ok;  n_kind = r_kind;  n_flag = r_flag;  n_wr = r_wr;  n_cv = r_cv;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_f = i_req.freq_khz;
                    n_ok = 1'b0;
                    if (i_req.freq_khz == '0 || i_req.freq_khz < r_min
                        || i_req.freq_khz > r_max) begin
                        n_state = S_OUT;
                    end else begin
                        n_fp   = FP_W'(i_req.freq_khz);
                        n_main = 1'b1;
                        n_dvd  = DIV_W'(M_START_NUM + FM_W'(i_req.freq_khz) - FM_W'(1));
                        n_rem  = '0;
                        n_dvs  = DVS_W'(i_req.freq_khz);
                        n_cnt  = CNT_W'(DIV_W);
                        n_ret  = S_PM_DIVD;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_rem = w_diff[DVS_W] ? w_rem_sh : w_diff[DVS_W-1:0];
                n_dvd = {r_dvd[DIV_W-2:0], ~w_diff[DVS_W]};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = r_ret;
                end
            end
            S_PM_DIVD: begin
                // m0 = ceil(50000/f), f*m0 = N - remainder
                n_m0  = r_dvd[M_W-1:0];
                n_m   = r_dvd[M_W-1:0];
                n_fm0 = w_nstart - r_rem[FM_W-1:0];
                n_fm  = w_nstart - r_rem[FM_W-1:0];
                n_dvd = DIV_W'(HALF_VCO_KHZ);
                n_rem = '0;
                n_dvs = DVS_W'(w_nstart - r_rem[FM_W-1:0]);
                n_cnt = CNT_W'(DIV_W);
                n_ret = S_PM_MODD;
                n_state = S_DIV;
            end
            S_PM_MODD: begin
                if (r_rem != '0) begin
                    n_state = S_PM_END;
                end else if (w_fm_inc > FM_LIMIT) begin
                    n_m  = r_m0;
                    n_fm = r_fm0;
                    n_state = S_PM_END;
                end else begin
                    n_m   = w_m_inc;
                    n_fm  = w_fm_inc;
                    n_dvd = DIV_W'(HALF_VCO_KHZ);
                    n_rem = '0;
                    n_dvs = DVS_W'(w_fm_inc);
                    n_cnt = CNT_W'(DIV_W);
                    n_ret = S_PM_MODD;
                    n_state = S_DIV;
                end
            end
            S_PM_END: begin
                if (r_main) begin
                    if (r_m > M_MAX) begin
                        n_state = S_OUT;
                    end else begin
                        n_mm  = r_m[9:0];
                        n_fmm = r_fm;
                        n_ga  = V_NUMER;
                        n_gb  = DVS_W'(r_fm);
                        n_state = S_GCD;
                    end
                end else begin
                    if (r_m == M_W'(1)) begin
                        n_any1 = 1'b1;
                    end else begin
                        n_any2 = 1'b1;
                        if (r_m - M_W'(1) != FLAG_COARSE) begin
                            n_off10 = 1'b1;
                        end
                    end
                    n_i = r_i + RI_W'(1);
                    n_state = S_RUN;
                end
            end
            S_GCD: begin
                n_rem = '0;
                n_cnt = CNT_W'(DIV_W);
                n_state = S_DIV;
                if (r_gb == '0) begin
                    n_g   = r_ga;
                    n_dvd = DIV_W'(V_NUMER);
                    n_dvs = r_ga;
                    n_ret = S_PD;
                end else begin
                    n_dvd = DIV_W'(r_ga);
                    n_dvs = r_gb;
                    n_ret = S_GCDD;
                end
            end
            S_GCDD: begin
                n_ga = r_gb;
                n_gb = r_rem;
                n_state = S_GCD;
            end
            S_PD: begin
                n_p   = r_dvd[P_W-1:0];
                n_dvd = DIV_W'(r_fmm);
                n_rem = '0;
                n_dvs = r_g;
                n_cnt = CNT_W'(DIV_W);
                n_ret = S_QD;
                n_state = S_DIV;
            end
            S_QD: begin
                n_q   = r_dvd[Q_W-1:0];
                n_dvd = DIV_W'(r_fmm + K_STEP_M1);
                n_rem = '0;
                n_dvs = K_STEP;
                n_cnt = CNT_W'(DIV_W);
                n_ret = S_KD;
                n_state = S_DIV;
            end
            S_KD: begin
                n_kk = r_dvd[KK_W-1:0];
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod = w_prod;
                n_state = S_A;
            end
            S_A: begin
                n_dvd = DIV_W'(w_sum) << A_SHIFT;
                n_rem = '0;
                n_dvs = w_q7;
                n_cnt = CNT_W'(DIV_W);
                n_ret = S_AD;
                n_state = S_DIV;
            end
            S_AD: begin
                n_a   = r_dvd[31:0];
                n_num = NORM_BITS'(r_p);
                n_den = 30'(r_q);
                n_state = S_NORM;
            end
            S_NORM: begin
                if (!r_num[NORM_BITS-1]) begin
                    n_num = {r_num[NORM_BITS-2:0], 1'b0};
                    n_den = {r_den[28:0], 1'b0};
                end else begin
                    n_dvd = DIV_W'(r_f);
                    n_rem = '0;
                    n_dvs = RUN_DIV;
                    n_cnt = CNT_W'(DIV_W);
                    n_ret = S_BASED;
                    n_state = S_DIV;
                end
            end
            S_BASED: begin
                n_base  = r_f - FREQ_W'(r_rem);
                n_i     = '0;
                n_any1  = 1'b0;
                n_any2  = 1'b0;
                n_off10 = 1'b0;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (r_i == RUN_END) begin
                    n_state = S_FIN;
                end else if (w_fp_run == '0) begin
                    n_i = r_i + RI_W'(1);
                end else begin
                    n_fp   = w_fp_run;
                    n_main = 1'b0;
                    n_dvd  = DIV_W'(M_START_NUM + FM_W'(w_fp_run) - FM_W'(1));
                    n_rem  = '0;
                    n_dvs  = DVS_W'(w_fp_run);
                    n_cnt  = CNT_W'(DIV_W);
                    n_ret  = S_PM_DIVD;
                    n_state = S_DIV;
                end
            end
            S_FIN: begin
                n_ok = 1'b1;
                n_flag = 1'b0;
                if (!r_any2) begin
                    n_kind = KIND_ONE;
                    n_wr   = 1'b0;
                end else if (r_any1) begin
                    n_kind = KIND_MIXED;
                    n_wr   = 1'b1;
                    n_flag = (r_mm == 10'd1);
                end else begin
                    n_kind = KIND_TWO;
                    n_wr   = r_off10;
                end
                if (n_wr) begin
                    n_cv = n_flag ? FLAG_COARSE[9:0] : r_mm - 10'd1;
                end else begin
                    n_cv = '0;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_plan.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min   <= MIN_KHZ_RST;
            r_max   <= MAX_KHZ_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                if (i_cfg.index == REG_MIN_KHZ) begin
                    r_min <= i_cfg.data;
                end else if (i_cfg.index == REG_MAX_KHZ) begin
                    r_max <= i_cfg.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;  r_dvd <= n_dvd;  r_rem <= n_rem;  r_dvs <= n_dvs;  r_cnt <= n_cnt;
        r_f <= n_f;  r_fp <= n_fp;  r_main <= n_main;
        r_m <= n_m;  r_m0 <= n_m0;  r_fm <= n_fm;  r_fm0 <= n_fm0;  r_fmm <= n_fmm;
        r_mm <= n_mm;  r_ga <= n_ga;  r_gb <= n_gb;  r_g <= n_g;  r_p <= n_p;  r_q <= n_q;
        r_kk <= n_kk;  r_prod <= n_prod;  r_a <= n_a;  r_num <= n_num;  r_den <= n_den;
        r_base <= n_base;  r_i <= n_i;  r_any1 <= n_any1;  r_any2 <= n_any2;
        r_off10 <= n_off10;  r_ok <= n_ok;  r_kind <= n_kind;  r_flag <= n_flag;
        r_wr <= n_wr;  r_cv <= n_cv;
    end

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);

    assign o_plan.valid          = (r_state == S_OUT);
    assign o_plan.ok             = r_ok;
    assign o_plan.coarse_m       = r_ok ? r_mm : '0;
    assign o_plan.fine_num       = r_ok ? w_num64[37:0] : '0;
    assign o_plan.fine_den       = r_ok ? r_den : '0;
    assign o_plan.a_word         = r_ok ? r_a : '0;
    assign o_plan.run_class      = r_ok ? r_kind : '0;
    assign o_plan.coarse_flag    = r_ok & r_flag;
    assign o_plan.coarse_written = r_ok & r_wr;
    assign o_plan.coarse_value   = r_ok ? r_cv : '0;

    a_norm_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_plan.valid && o_plan.ok) |-> r_num[NORM_BITS-1])
        else $error("fine numerator not normalized");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0))
        else $error("divider started with zero divisor");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_plan.valid && !o_plan.ok) |-> (o_plan.coarse_m == '0 && o_plan.a_word == '0
            && o_plan.coarse_written == 1'b0))
        else $error("rejected plan carries data");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while busy");

endmodule
